// ===== rtl/srs_pkg.sv =====
// ----------------------------------------------------------------------------
// srs_pkg: shared types and constants of the sender-report scheduler
// Holds the report descriptor, the event codes and the fixed RTCP constants.
// ----------------------------------------------------------------------------
package srs_pkg;

    // Event codes on the input side.
    typedef enum logic [0:0] {
        CMD_PACKET = 1'b0,
        CMD_START  = 1'b1
    } t_cmd;

    // Word positions inside one sender report.
    typedef enum logic [2:0] {
        W_HEADER  = 3'd0,
        W_SSRC    = 3'd1,
        W_NTP_SEC = 3'd2,
        W_NTP_FRC = 3'd3,
        W_RTP_TS  = 3'd4,
        W_PKT_CNT = 3'd5,
        W_BYTE_CNT = 3'd6
    } t_word_idx;

    localparam logic [1:0]  SR_VERSION  = 2'd2;
    localparam logic [7:0]  SR_PTYPE    = 8'd200;
    localparam logic [15:0] SR_LENGTH   = 16'd6;
    localparam logic [31:0] SR_HEADER   = {SR_VERSION, 6'd0, SR_PTYPE, SR_LENGTH};

    localparam logic [15:0] MIN_RTP_LEN     = 16'd12;
    localparam int          CREDIT_DIV      = 80;
    localparam logic [31:0] MIN_GAP_SECONDS = 32'd5;

    localparam int          CL_WIDTH        = 10;
    localparam int          LIMIT_WIDTH     = 17;
    localparam logic [CL_WIDTH-1:0]    CL_RESET    = 10'd28;
    localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = LIMIT_WIDTH'(28 * CREDIT_DIV);

    // Everything the back end needs to build one report.
    typedef struct packed {
        logic [31:0] ssrc;
        logic [31:0] ntp_sec;
        logic [31:0] ntp_frac;
        logic [31:0] rtp_ts;
        logic [31:0] pkt_count;
        logic [31:0] byte_count;
    } t_report;

endpackage

// ===== rtl/srs_front.sv =====
// ----------------------------------------------------------------------------
// srs_front: event classification and counters
// Updates the packet, byte and credit counters and decides when a report is due.
// ----------------------------------------------------------------------------
module srs_front
    import srs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_cmd,
    input  logic [15:0]         i_packet_length,
    input  logic [31:0]         i_rtp_timestamp,
    input  logic [31:0]         i_source_id,
    input  logic [63:0]         i_now_ntp,
    input  logic                i_cfg_we,
    input  logic [CL_WIDTH-1:0] i_cfg_data,
    output logic                o_push,
    output t_report             o_report
);

    logic [31:0]            r_pkt_total, n_pkt_total;
    logic [31:0]            r_byte_total, n_byte_total;
    logic [31:0]            r_credit, n_credit;
    logic [31:0]            r_last_sec, n_last_sec;
    logic [LIMIT_WIDTH-1:0] r_limit, n_limit;

    logic [LIMIT_WIDTH-1:0] cfg_ext;
    logic [31:0]            now_sec;
    logic [31:0]            credit_sum;
    logic                   is_start;
    logic                   is_packet;
    logic                   credit_ok;
    logic                   time_ok;

    assign now_sec  = i_now_ntp[63:32];
    assign cfg_ext  = LIMIT_WIDTH'(i_cfg_data);

    // floor(credit / 80) >= length is the same as credit >= 80 * length.
    assign credit_sum = r_credit + 32'(i_packet_length);
    assign credit_ok  = credit_sum >= 32'(r_limit);
    assign time_ok    = now_sec >= (r_last_sec + MIN_GAP_SECONDS);

    assign is_start  = i_valid && (t_cmd'(i_cmd) == CMD_START);
    assign is_packet = i_valid && (t_cmd'(i_cmd) == CMD_PACKET)
                       && (i_packet_length >= MIN_RTP_LEN);

    always_comb begin
        n_limit      = i_cfg_we ? ((cfg_ext << 6) + (cfg_ext << 4)) : r_limit;
        n_pkt_total  = r_pkt_total;
        n_byte_total = r_byte_total;
        n_credit     = r_credit;
        n_last_sec   = r_last_sec;
        o_push       = 1'b0;
        if (is_start) begin
            n_last_sec = now_sec;
        end else if (is_packet) begin
            n_pkt_total  = r_pkt_total + 32'd1;
            n_byte_total = r_byte_total + 32'(i_packet_length);
            n_credit     = credit_sum;
            if (credit_ok && time_ok) begin
                o_push     = 1'b1;
                n_credit   = 32'd0;
                n_last_sec = now_sec;
            end
        end
    end

    assign o_report.ssrc       = i_source_id;
    assign o_report.ntp_sec    = now_sec;
    assign o_report.ntp_frac   = i_now_ntp[31:0];
    assign o_report.rtp_ts     = i_rtp_timestamp;
    assign o_report.pkt_count  = n_pkt_total;
    assign o_report.byte_count = n_byte_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pkt_total  <= 32'd0;
            r_byte_total <= 32'd0;
            r_credit     <= 32'd0;
            r_last_sec   <= 32'd0;
            r_limit      <= LIMIT_RESET;
        end else begin
            r_pkt_total  <= n_pkt_total;
            r_byte_total <= n_byte_total;
            r_credit     <= n_credit;
            r_last_sec   <= n_last_sec;
            r_limit      <= n_limit;
        end
    end

endmodule

// ===== rtl/srs_queue.sv =====
// ----------------------------------------------------------------------------
// srs_queue: report descriptor queue
// A small first-in first-out store that parts the front end from the back end.
// ----------------------------------------------------------------------------
module srs_queue
    import srs_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_report i_data,
    input  logic    i_pop,
    output logic    o_full,
    output logic    o_valid,
    output t_report o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    t_report             r_mem [DEPTH];
    logic [PTR_W-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                do_push;
    logic                do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ===== rtl/srs_back.sv =====
// ----------------------------------------------------------------------------
// srs_back: report serializer
// Walks the head descriptor of the queue out as seven report words.
// ----------------------------------------------------------------------------
module srs_back
    import srs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_head_valid,
    input  t_report     i_head,
    input  logic        i_pop,
    output logic        o_release,
    output logic        o_empty,
    output logic [31:0] o_report_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    t_word_idx r_idx, n_idx;
    logic      take;

    assign o_empty      = !i_head_valid;
    assign take         = i_pop && i_head_valid;
    assign o_last_word  = (r_idx == W_BYTE_CNT);
    assign o_release    = take && o_last_word;
    assign o_word_index = r_idx;

    always_comb begin
        n_idx = r_idx;
        if (take) begin
            n_idx = o_last_word ? W_HEADER : t_word_idx'(r_idx + 3'd1);
        end
    end

    always_comb begin
        unique case (r_idx)
            W_HEADER:   o_report_word = SR_HEADER;
            W_SSRC:     o_report_word = i_head.ssrc;
            W_NTP_SEC:  o_report_word = i_head.ntp_sec;
            W_NTP_FRC:  o_report_word = i_head.ntp_frac;
            W_RTP_TS:   o_report_word = i_head.rtp_ts;
            W_PKT_CNT:  o_report_word = i_head.pkt_count;
            W_BYTE_CNT: o_report_word = i_head.byte_count;
            default:    o_report_word = SR_HEADER;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= W_HEADER;
        end else begin
            r_idx <= n_idx;
        end
    end

endmodule

// ===== rtl/rtcp_sender_report_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// rtcp_sender_report_scheduler_unit: RTCP sender-report scheduler, top level
// A due report enters the descriptor queue at the edge that accepts its packet
// event; with the queue empty, its header word is on the result ports right
// after it. The seven words drain at one word per cycle while pop is high.
// Throughput: one event per cycle; the descriptor queue depth sets how many
// reports may wait before full rises and the event side stalls.
// Reset (synchronous, active low) clears all counters, sets the compound length
// to 28 bytes and empties the queue; there is no clearing pass.
// ----------------------------------------------------------------------------
module rtcp_sender_report_scheduler_unit
    import srs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Event side
    input  logic                push,
    output logic                full,
    input  logic                i_cmd,
    input  logic [15:0]         i_packet_length,
    input  logic [31:0]         i_rtp_timestamp,
    input  logic [31:0]         i_source_id,
    input  logic [63:0]         i_now_ntp,
    // Configuration
    input  logic                i_cfg_we,
    input  logic [CL_WIDTH-1:0] i_cfg_data,
    // Result side
    output logic                empty,
    input  logic                pop,
    output logic [31:0]         o_report_word,
    output logic [2:0]          o_word_index,
    output logic                o_last_word
);

    // An event is taken whenever the queue has room. Most events never make
    // a report, but holding the gate on queue space keeps the front simple.
    logic    accept;
    logic    q_push;
    t_report q_in;
    logic    q_valid;
    t_report q_head;
    logic    q_release;

    assign accept = push && !full;

    // The front end updates the counters and, when both the byte credit
    // and the five-second gap allow it, hands a report descriptor on.
    srs_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (accept),
        .i_cmd           (i_cmd),
        .i_packet_length (i_packet_length),
        .i_rtp_timestamp (i_rtp_timestamp),
        .i_source_id     (i_source_id),
        .i_now_ntp       (i_now_ntp),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .o_push          (q_push),
        .o_report        (q_in)
    );

    // Descriptors wait here so that the event side keeps running while
    // the result side stalls on a report.
    srs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_release),
        .o_full  (full),
        .o_valid (q_valid),
        .o_data  (q_head)
    );

    // The back end shows the head descriptor one word at a time and frees
    // it when the last word is taken.
    srs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head_valid  (q_valid),
        .i_head        (q_head),
        .i_pop         (pop),
        .o_release     (q_release),
        .o_empty       (empty),
        .o_report_word (o_report_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

endmodule

// ===== rtl/srs_checker.sv =====
// ----------------------------------------------------------------------------
// srs_checker: port-level checks of the sender-report scheduler
// Watches the result side for well-formed report word sequences.
// ----------------------------------------------------------------------------
module srs_checker
    import srs_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [31:0] o_report_word,
    input logic [2:0]  o_word_index,
    input logic        o_last_word
);

    // The last-word flag marks exactly the final position.
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_last_word == (o_word_index == W_BYTE_CNT)))
        else $error("last_word does not match word index");

    // Every report starts with the fixed header.
    a_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_word_index == W_HEADER)) |-> (o_report_word == SR_HEADER))
        else $error("report header word is wrong");

    // Once a report starts, its remaining words follow in order with no gap.
    a_sequence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && !o_last_word)
        |=> (!empty && (o_word_index == $past(o_word_index) + 3'd1)))
        else $error("report words out of order or interrupted");

    // After a finished report the next one starts at the header.
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && o_last_word) |=> (o_word_index == W_HEADER))
        else $error("report did not restart at header");

    // Coming out of reset the block is empty and accepting. The check runs
    // at the first edge with reset released, after a reset edge took effect.
    a_reset: assert property (@(posedge i_clk)
        (!$past(i_rst_n) && i_rst_n) |-> (empty && !full))
        else $error("block not empty after reset");

endmodule

bind rtcp_sender_report_scheduler_unit srs_checker u_srs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .full          (full),
    .empty         (empty),
    .pop           (pop),
    .o_report_word (o_report_word),
    .o_word_index  (o_word_index),
    .o_last_word   (o_last_word)
);
